@@ sv/e2s_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2s_pkg
// Shared types and constants of the EUC-JP to Shift_JIS stream converter.
// ----------------------------------------------------------------------------
package e2s_pkg;

	localparam logic [7:0] BYTE_NUL      = 8'h00;
	localparam logic [7:0] BYTE_ASCII_HI = 8'h80;
	localparam logic [7:0] BYTE_SS2      = 8'h8E;
	localparam logic [7:0] BYTE_BAD_HI   = 8'h9F;
	localparam logic [7:0] KANA_LO       = 8'hA0;
	localparam logic [7:0] KANA_HI       = 8'hDF;
	localparam logic [7:0] LEAD_BIAS     = 8'h5F;
	localparam logic [7:0] ROW_XOR       = 8'hA0;
	localparam logic [7:0] TRAIL_EVEN    = 8'h02;
	localparam logic [7:0] TRAIL_ODD_LO  = 8'h61;
	localparam logic [7:0] TRAIL_ODD_HI  = 8'h60;
	localparam logic [7:0] TRAIL_SPLIT   = 8'hE0;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_KANA    = 2'd1,
		ST_BAD_LEAD    = 2'd2,
		ST_END_IN_CHAR = 2'd3
	} status_t;

	typedef enum logic {
		PH_FIRST  = 1'b0,
		PH_SECOND = 1'b1
	} phase_t;

	// One queued job: a single result, or a two-byte pair.
	typedef struct packed {
		logic    pair;
		logic [7:0] byte0;
		logic [7:0] byte1;
		status_t status;
		logic    end_mark;
	} job_t;

endpackage
`default_nettype wire

@@ sv/e2s_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2s_front
// Accepts source bytes, tracks the held lead byte and classifies each byte
// into a job for the back end.
// ----------------------------------------------------------------------------
module e2s_front import e2s_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // in_byte
	input  wire logic       s_tlast,   // end_of_input
	input  wire logic       q_full,
	output logic            push,
	output job_t            push_job
);

	logic       pend_q;
	logic       pend_d;
	logic [7:0] held_lead_q;
	logic       hold;
	logic       take;
	logic [7:0] s1;
	logic [7:0] s2;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		s1 = ((held_lead_q - LEAD_BIAS) >> 1) ^ ROW_XOR;
		if (!held_lead_q[0]) begin
			s2 = s_tdata - TRAIL_EVEN;
		end else if (s_tdata < TRAIL_SPLIT) begin
			s2 = s_tdata - TRAIL_ODD_LO;
		end else begin
			s2 = s_tdata - TRAIL_ODD_HI;
		end
	end

	always_comb begin
		push     = 1'b0;
		hold     = 1'b0;
		pend_d   = pend_q;
		push_job = '{pair: 1'b0, byte0: BYTE_NUL, byte1: BYTE_NUL,
			status: ST_OK, end_mark: s_tlast};
		if (take) begin
			if (!pend_q) begin
				if (s_tdata == BYTE_NUL) begin
					push              = 1'b1;
					push_job.end_mark = 1'b1;
				end else if (s_tdata < BYTE_ASCII_HI) begin
					push           = 1'b1;
					push_job.byte0 = s_tdata;
				end else if (s_tdata > BYTE_BAD_HI || s_tdata == BYTE_SS2) begin
					if (s_tlast) begin
						push              = 1'b1;
						push_job.status   = ST_END_IN_CHAR;
						push_job.end_mark = 1'b1;
					end else begin
						hold   = 1'b1;
						pend_d = 1'b1;
					end
				end else begin
					push            = 1'b1;
					push_job.status = ST_BAD_LEAD;
				end
			end else begin
				pend_d = 1'b0;
				push   = 1'b1;
				if (s_tdata == BYTE_NUL) begin
					push_job.status   = ST_END_IN_CHAR;
					push_job.end_mark = 1'b1;
				end else if (held_lead_q == BYTE_SS2) begin
					if (s_tdata < KANA_LO || s_tdata > KANA_HI) begin
						push_job.status = ST_BAD_KANA;
					end else begin
						push_job.byte0 = s_tdata;
					end
				end else begin
					push_job.pair  = 1'b1;
					push_job.byte0 = s1;
					push_job.byte1 = s2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hold) begin
			held_lead_q <= s_tdata;
		end
	end

endmodule
`default_nettype wire

@@ sv/e2s_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2s_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module e2s_queue import e2s_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL) else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

@@ sv/e2s_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// e2s_back
// Drains jobs from the queue and emits one or two result beats per job
// through a registered output stage.
// ----------------------------------------------------------------------------
module e2s_back import e2s_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic empty,
	output logic      pop,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic [2:0] m_tuser,  // status[1:0], end_mark[2]
	output logic      m_tlast    // last
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	status_t    out_status_q;
	logic       out_end_q;
	logic       out_last_q;
	logic       load;
	logic [7:0] nx_byte;
	logic       nx_end;
	logic       nx_last;

	assign load = (!out_valid_q || m_tready) && !empty;

	always_comb begin
		phase_d = phase_q;
		pop     = 1'b0;
		nx_byte = head.byte0;
		nx_end  = head.end_mark;
		nx_last = 1'b1;
		case (phase_q)
			PH_FIRST: begin
				if (head.pair) begin
					nx_end  = 1'b0;
					nx_last = 1'b0;
					if (load) begin
						phase_d = PH_SECOND;
					end
				end else begin
					pop = load;
				end
			end
			PH_SECOND: begin
				nx_byte = head.byte1;
				pop     = load;
				if (load) begin
					phase_d = PH_FIRST;
				end
			end
			default: phase_d = PH_FIRST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= nx_byte;
			out_status_q <= head.status;
			out_end_q    <= nx_end;
			out_last_q   <= nx_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_end_q, out_status_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_second_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SECOND |-> !empty) else $error("second beat without job");
	a_first_beat_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> phase_q == PH_SECOND)
		else $error("first beat of pair without second pending");
`endif

endmodule
`default_nettype wire

@@ sv/eucjp_to_sjis_stream_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eucjp_to_sjis_stream_unit
// EUC-JP to Shift_JIS byte stream converter.
//
// Slave channel s_*: one EUC-JP byte per beat in s_tdata, s_tlast marks the
// last byte of the source buffer. Master channel m_*: one Shift_JIS byte per
// beat in m_tdata; m_tuser carries status (bits 1:0) and end_mark (bit 2);
// m_tlast marks the final beat caused by one source byte.
// A source byte is accepted every cycle while the job queue has room. A lead
// byte yields no beat unless s_tlast is set; its trail yields one beat (kana,
// errors) or two beats (JIS X 0208 pair). The first beat is registered in the
// job queue and then in the back-end output register. While m_tready is high,
// output runs at one beat per cycle, so pairs set the sustained rate: the
// back-end register stage emits one beat a cycle and the queue of QUEUE_DEPTH
// jobs absorbs bursts of pairs. When m_tready is low the output beat holds,
// the queue fills and then s_tready drops. Reset empties the queue, drops any
// held lead byte and clears m_tvalid.
// ----------------------------------------------------------------------------
module eucjp_to_sjis_stream_unit import e2s_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // in_byte
	input  wire logic       s_tlast,   // end_of_input
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic [2:0]      m_tuser,   // status[1:0], end_mark[2]
	output logic            m_tlast    // last
);

	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic full;
	logic empty;

	e2s_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (full),
		.push     (push),
		.push_job (push_job)
	);

	e2s_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	e2s_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

@@ sim/sjis_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjis_stream_checker
// Watches both stream channels of the EUC-JP to Shift_JIS converter. Every
// accepted source byte runs through an independent model of the conversion,
// which queues the Shift_JIS beats it should cause. Every output beat is
// compared field by field against the oldest queued beat. Mismatch, pending
// and beat counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module sjis_stream_checker import e2s_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,
	input  wire logic [2:0] m_tuser,
	input  wire logic       m_tlast,
	output int              mismatch_count,
	output int              outstanding,
	output int              beat_count,
	output int              error_beat_count
);

	typedef struct packed {
		logic [7:0] sj_byte;
		status_t    status;
		logic       end_mark;
		logic       last;
	} sjis_beat_t;

	sjis_beat_t sjis_expected[$];
	logic       lead_held = 1'b0;
	logic [7:0] lead_byte = 8'h00;
	int         mismatches = 0;
	int         beats = 0;
	int         error_beats = 0;

	task automatic push_beat(input logic [7:0] b, input status_t st, input logic em,
			input logic ls);
		sjis_beat_t nb;
		nb.sj_byte  = b;
		nb.status   = st;
		nb.end_mark = em;
		nb.last     = ls;
		sjis_expected.push_back(nb);
	endtask

	task automatic predict_sjis(input logic [7:0] b, input logic eoi);
		logic [7:0] diff;
		logic [7:0] row;
		logic [7:0] col;
		if (!lead_held) begin
			if (b == BYTE_NUL) begin
				push_beat(BYTE_NUL, ST_OK, 1'b1, 1'b1);
			end else if (b < BYTE_ASCII_HI) begin
				push_beat(b, ST_OK, eoi, 1'b1);
			end else if (b > BYTE_BAD_HI || b == BYTE_SS2) begin
				if (eoi) begin
					push_beat(BYTE_NUL, ST_END_IN_CHAR, 1'b1, 1'b1);
				end else begin
					lead_byte = b;
					lead_held = 1'b1;
				end
			end else begin
				push_beat(BYTE_NUL, ST_BAD_LEAD, eoi, 1'b1);
			end
		end else begin
			lead_held = 1'b0;
			if (b == BYTE_NUL) begin
				push_beat(BYTE_NUL, ST_END_IN_CHAR, 1'b1, 1'b1);
			end else if (lead_byte == BYTE_SS2) begin
				if (b < KANA_LO || b > KANA_HI)
					push_beat(BYTE_NUL, ST_BAD_KANA, eoi, 1'b1);
				else
					push_beat(b, ST_OK, eoi, 1'b1);
			end else begin
				diff = lead_byte - LEAD_BIAS;
				row  = (diff >> 1) ^ ROW_XOR;
				if (!lead_byte[0])
					col = b - TRAIL_EVEN;
				else if (b < TRAIL_SPLIT)
					col = b - TRAIL_ODD_LO;
				else
					col = b - TRAIL_ODD_HI;
				push_beat(row, ST_OK, 1'b0, 1'b0);
				push_beat(col, ST_OK, eoi, 1'b1);
			end
		end
	endtask

	task automatic check_beat();
		sjis_beat_t got;
		sjis_beat_t want;
		got.sj_byte  = m_tdata;
		got.status   = status_t'(m_tuser[1:0]);
		got.end_mark = m_tuser[2];
		got.last     = m_tlast;
		beats++;
		if (got.status != ST_OK)
			error_beats++;
		if (sjis_expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected beat %0d: byte %02h status %0d end %0b last %0b",
					beats, got.sj_byte, got.status, got.end_mark, got.last);
		end else begin
			want = sjis_expected.pop_front();
			if (got.sj_byte !== want.sj_byte || got.status !== want.status ||
					got.end_mark !== want.end_mark || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch on beat %0d: expected byte %02h status %0d end %0b",
						" last %0b, got byte %02h status %0d end %0b last %0b"},
						beats, want.sj_byte, want.status, want.end_mark, want.last,
						got.sj_byte, got.status, got.end_mark, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			sjis_expected.delete();
			lead_held = 1'b0;
			lead_byte = 8'h00;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				predict_sjis(s_tdata, s_tlast);
		end
		mismatch_count   <= mismatches;
		outstanding      <= sjis_expected.size();
		beat_count       <= beats;
		error_beat_count <= error_beats;
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the EUC-JP to Shift_JIS converter. A directed run covers
// ASCII extremes, terminators, kanji pairs of both lead parities, half-width
// kana, bad kana trails, invalid leads and strings cut inside a character.
// Random traffic follows, mostly well-formed sequences with random content
// plus noise and broken sequences, sent in bursts against a stalling sink
// that once holds off long enough to back the converter up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RANDOM_BYTES = 2000;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [7:0] BYTE_SS2_B = 8'h8E;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_THIRD,
		RX_MOSTLY
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	int         mismatch_count;
	int         outstanding;
	int         beat_count;
	int         error_beat_count;
	int         cycles = 0;
	int         bytes_sent = 0;
	int         burst_left = 0;
	logic       random_started;

	eucjp_to_sjis_stream_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sjis_stream_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tlast          (m_tlast),
		.mismatch_count   (mismatch_count),
		.outstanding      (outstanding),
		.beat_count       (beat_count),
		.error_beat_count (error_beat_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic rare_end();
		return ($urandom_range(0, 15) == 0);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       since_start;
		int       hold_left;
		bit       hold_done;
		m_tready    = 1'b0;
		mode        = RX_OPEN;
		mode_left   = 0;
		since_start = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (random_started && !hold_done)
				since_start++;
			if (since_start == 200 && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:  m_tready <= 1'b1;
					RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
					RX_THIRD: m_tready <= (mode_left % 3 == 0);
					default:  m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		int         kind;
		int         random_sent;
		logic [7:0] lead;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tlast        = 1'b0;
		random_started = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h41, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'hA1, 1'b0);
		send_byte(8'hA1, 1'b0);
		send_byte(8'hB0, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hE0, 1'b1);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h8E, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h8E, 1'b0);
		send_byte(8'hDF, 1'b1);
		send_byte(8'h8E, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h8E, 1'b0);
		send_byte(8'hE0, 1'b1);
		send_byte(8'h8F, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h9F, 1'b0);
		send_byte(8'hC8, 1'b1);
		send_byte(8'h8E, 1'b1);

		random_started <= 1'b1;
		random_sent = bytes_sent;
		while (bytes_sent - random_sent < RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				send_byte(8'($urandom_range(1, 127)), rare_end());
			end else if (kind < 55) begin
				send_byte(8'($urandom_range(8'hA0, 8'hFF)), 1'b0);
				if ($urandom_range(0, 7) != 0)
					send_byte(8'($urandom_range(8'hA1, 8'hFE)), rare_end());
				else
					send_byte(8'($urandom_range(1, 255)), rare_end());
			end else if (kind < 70) begin
				send_byte(BYTE_SS2_B, 1'b0);
				if ($urandom_range(0, 9) != 0)
					send_byte(8'($urandom_range(8'hA0, 8'hDF)), rare_end());
				else
					send_byte(8'($urandom_range(1, 255)), rare_end());
			end else if (kind < 80) begin
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (kind < 87) begin
				send_byte(8'($urandom_range(8'h80, 8'h9F)), rare_end());
			end else if (kind < 93) begin
				send_byte(8'h00, 1'($urandom_range(0, 1)));
			end else begin
				lead = ($urandom_range(0, 3) == 0) ? BYTE_SS2_B : 8'($urandom_range(8'hA0, 8'hFF));
				if ($urandom_range(0, 1) == 0) begin
					send_byte(lead, 1'b1);
				end else begin
					send_byte(lead, 1'b0);
					send_byte(8'h00, 1'($urandom_range(0, 1)));
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d EUC-JP bytes: directed cases, then ASCII, kanji pairs, kana, noise",
			bytes_sent);
		$display("and broken sequences; checked %0d Shift_JIS beats, %0d with an error status.",
			beat_count, error_beat_count);
		if (outstanding != 0)
			$display("%0d expected beats never arrived", outstanding);
		if (mismatch_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
